### hdl/affine_function_queue_composite_core_defines.svh
// ----------------------------------------------------------------------------
// affine_function_queue_composite_core_defines
// Assertion macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_FUNCTION_QUEUE_COMPOSITE_CORE_DEFINES_SVH
`define AFFINE_FUNCTION_QUEUE_COMPOSITE_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define AFQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AFQ_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

### hdl/afq_pkg.sv
// ----------------------------------------------------------------------------
// afq_pkg
// Types, constants and helpers for the affine function queue.
// ----------------------------------------------------------------------------
package afq_pkg;
	localparam int unsigned DefQueueDepth = 1024;
	localparam logic [29:0] ModP = 30'd998244353;
	localparam logic [29:0] InvExp = 30'd998244351;
	// Barrett factor floor(2^60 / P) for the product reduction.
	localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(ModP));

	localparam logic [1:0] ReqPush = 2'd0;
	localparam logic [1:0] ReqPop = 2'd1;
	localparam logic [1:0] ReqEval = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StEmpty = 2'd1;
	localparam logic [1:0] StFull = 2'd2;
	localparam logic [1:0] StZero = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [29:0] coef_a;
		logic [29:0] coef_b;
		logic [29:0] query_x;
	} afq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [29:0] result_value;
	} afq_out_t;

	// Datapath operation codes issued by the controller.
	typedef enum logic [2:0] {
		OpNone, OpLoad, OpMul, OpAddStore, OpRead
	} afq_op_t;

	// Multiplier operand/destination selections.
	localparam logic [2:0] RegS = 3'd0;
	localparam logic [2:0] RegO = 3'd1;
	localparam logic [2:0] RegA = 3'd2;
	localparam logic [2:0] RegB = 3'd3;
	localparam logic [2:0] RegX = 3'd4;
	localparam logic [2:0] RegR = 3'd5;
	localparam logic [2:0] RegT = 3'd6;

	typedef struct packed {
		afq_op_t op;
		logic [2:0] src1;
		logic [2:0] src2;
		logic [2:0] dst;
		logic add_o;
		logic [1:0] status;
		logic out_load;
	} afq_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic a_zero;
	} afq_sts_t;

	function automatic logic [29:0] reduce_in(input logic [29:0] v);
		return (v >= ModP) ? v - ModP : v;
	endfunction

	function automatic logic [29:0] add_mod(input logic [29:0] x, input logic [29:0] y);
		logic [30:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, ModP}) ? 30'(s - {1'b0, ModP}) : s[29:0];
	endfunction
endpackage

### hdl/afq_mulmod.sv
// ----------------------------------------------------------------------------
// afq_mulmod
// Pipelined modular multiplier: 30x30 product, then a Barrett reduction.
// ----------------------------------------------------------------------------
module afq_mulmod (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [29:0] op_x,
	input logic [29:0] op_y,
	output logic done,
	output logic [29:0] prod
);
	import afq_pkg::*;

	localparam logic [31:0] TwoP = {1'b0, ModP, 1'b0};

	logic [59:0] prod_s1;
	logic [30:0] quot_s2;
	logic [31:0] low_s2;
	logic [31:0] low_s3;
	logic [31:0] qp_s3;
	logic [31:0] rem_s4;
	logic [29:0] prod_q;
	logic [3:0] vld_q;
	logic [61:0] quot_full;
	logic [60:0] qp_full;

	// Quotient estimate from the top product bits, then its multiple of P.
	always_comb begin
		quot_full = 62'(prod_s1[59:29]) * 62'(BarrettMu);
		qp_full = 61'(quot_s2) * 61'(ModP);
	end

	// Stage valid bits; done is registered alongside the final result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done <= 1'b0;
		end else begin
			vld_q <= {vld_q[2:0], start};
			done <= vld_q[3];
		end
	end

	// The estimate leaves a remainder below 3P, so one subtraction of 2P or P follows.
	always_ff @(posedge clk) begin
		prod_s1 <= 60'(op_x) * 60'(op_y);
		quot_s2 <= quot_full[61:31];
		low_s2 <= prod_s1[31:0];
		qp_s3 <= qp_full[31:0];
		low_s3 <= low_s2;
		rem_s4 <= low_s3 - qp_s3;
		if (vld_q[3]) begin
			if (rem_s4 >= TwoP) begin
				prod_q <= 30'(rem_s4 - TwoP);
			end else if (rem_s4 >= {2'b00, ModP}) begin
				prod_q <= 30'(rem_s4 - {2'b00, ModP});
			end else begin
				prod_q <= rem_s4[29:0];
			end
		end
	end

	assign prod = prod_q;
endmodule

### hdl/afq_datapath.sv
// ----------------------------------------------------------------------------
// afq_datapath
// Queue memory, composite registers, working registers and the multiplier.
// ----------------------------------------------------------------------------
module afq_datapath #(
	parameter int unsigned QUEUE_DEPTH = afq_pkg::DefQueueDepth
) (
	input logic clk,
	input logic arst_n,
	input afq_pkg::afq_in_t in_item,
	input logic in_take,
	input afq_pkg::afq_cmd_t cmd,
	input logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	input logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	output afq_pkg::afq_sts_t sts,
	output afq_pkg::afq_out_t out_item
);
	import afq_pkg::*;

	logic [59:0] mem [QUEUE_DEPTH];
	logic [59:0] rd_q;
	logic [29:0] s_q, o_q, a_q, b_q, x_q, r_q, t_q;
	logic [29:0] opx, opy, prod;
	logic mul_start;
	logic mul_done;

	function automatic logic [29:0] pick(input logic [2:0] sel, input logic [29:0] s,
		input logic [29:0] o, input logic [29:0] a, input logic [29:0] b,
		input logic [29:0] x, input logic [29:0] r, input logic [29:0] t);
		case (sel)
			RegS: return s;
			RegO: return o;
			RegA: return a;
			RegB: return b;
			RegX: return x;
			RegR: return r;
			default: return t;
		endcase
	endfunction

	assign opx = pick(cmd.src1, s_q, o_q, a_q, b_q, x_q, r_q, t_q);
	assign opy = pick(cmd.src2, s_q, o_q, a_q, b_q, x_q, r_q, t_q);
	assign mul_start = (cmd.op == OpMul);

	afq_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.op_x(opx), .op_y(opy), .done(mul_done), .prod(prod)
	);

	assign sts = '{mul_done: mul_done, a_zero: (a_q == '0)};

	// Queue memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.op == OpAddStore && cmd.dst == RegS) begin
			mem[wr_addr] <= {a_q, b_q};
		end
		rd_q <= mem[rd_addr];
	end

	// Composite totals reset to the identity function; a push commits its slope at the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= 30'd1;
			o_q <= '0;
		end else if (mul_done && cmd.dst == RegS) begin
			s_q <= prod;
		end else if (mul_done && cmd.dst == RegO) begin
			o_q <= cmd.add_o ? add_mod(prod, b_q) : add_mod(prod, o_q);
		end else if (cmd.op == OpAddStore && cmd.dst == RegS) begin
			s_q <= t_q;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_q <= reduce_in(in_item.coef_a);
			b_q <= reduce_in(in_item.coef_b);
			x_q <= reduce_in(in_item.query_x);
		end else if (cmd.op == OpRead) begin
			a_q <= rd_q[59:30];
			b_q <= (rd_q[29:0] == '0) ? '0 : ModP - rd_q[29:0];
			r_q <= 30'd1;
		end else if (cmd.op == OpLoad) begin
			t_q <= a_q;
		end else if (mul_done) begin
			case (cmd.dst)
				RegA: a_q <= prod;
				RegB: b_q <= prod;
				RegR: r_q <= prod;
				RegT: t_q <= prod;
				RegX: x_q <= add_mod(prod, o_q);
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item.status <= cmd.status;
			out_item.result_value <= (cmd.src1 == RegX) ? x_q : '0;
		end
	end
endmodule

### hdl/afq_ctrl.sv
// ----------------------------------------------------------------------------
// afq_ctrl
// Sequencer for push, pop and evaluate, with the queue pointers.
// ----------------------------------------------------------------------------
module afq_ctrl #(
	parameter int unsigned QUEUE_DEPTH = afq_pkg::DefQueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	output logic out_valid,
	input logic out_ready,
	input afq_pkg::afq_sts_t sts,
	output afq_pkg::afq_cmd_t cmd,
	output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr
);
	import afq_pkg::*;
	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);

	localparam logic [3:0] SIdle = 4'd0, SDecode = 4'd1, SWait = 4'd2, SRead = 4'd3,
		SRead2 = 4'd4, SInvSq = 4'd5, SInvMul = 4'd6, SDone = 4'd7, SOut = 4'd8,
		SIssue = 4'd9;

	logic [3:0] state_q;
	logic [1:0] req_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [4:0] bit_q;
	logic [2:0] step_q;
	logic [1:0] st_q;
	logic xout_q;

	assign in_ready = (state_q == SIdle) && !out_valid;
	assign rd_addr = head_q;
	assign wr_addr = tail_q;

	// Command decode for the current step.
	always_comb begin
		cmd = '{op: OpNone, src1: RegS, src2: RegS, dst: RegT, add_o: 1'b0,
			status: st_q, out_load: 1'b0};
		case (state_q)
			SIssue: begin
				cmd.op = OpMul;
				case ({req_q, step_q})
					{ReqPush, 3'd0}: begin cmd.src1 = RegS; cmd.src2 = RegA; end
					{ReqPush, 3'd1}: begin cmd.src1 = RegA; cmd.src2 = RegO; end
					{ReqEval, 3'd0}: begin cmd.src1 = RegS; cmd.src2 = RegX; end
					{ReqPop, 3'd0}: begin cmd.src1 = RegB; cmd.src2 = RegR; end
					{ReqPop, 3'd1}: begin cmd.src1 = RegS; cmd.src2 = RegB; end
					default: begin cmd.src1 = RegS; cmd.src2 = RegR; end
				endcase
			end
			SWait: begin
				case ({req_q, step_q})
					{ReqPush, 3'd0}: cmd.dst = RegT;
					{ReqPush, 3'd1}: begin cmd.dst = RegO; cmd.add_o = 1'b1; end
					{ReqEval, 3'd0}: cmd.dst = RegX;
					{ReqPop, 3'd0}: cmd.dst = RegB;
					{ReqPop, 3'd1}: cmd.dst = RegO;
					default: cmd.dst = RegS;
				endcase
			end
			SInvSq: begin cmd.op = OpMul; cmd.src1 = RegA; cmd.src2 = RegA; end
			SInvMul: begin cmd.op = OpMul; cmd.src1 = RegR; cmd.src2 = RegA; end
			SRead2: cmd.op = OpRead;
			SDone: begin
				if (req_q == ReqPush && st_q == StOk) begin
					cmd.op = OpAddStore; cmd.dst = RegS;
				end
			end
			SOut: begin
				cmd.out_load = 1'b1;
				cmd.src1 = xout_q ? RegX : RegS;
			end
			default: ;
		endcase
		// Inverse iteration results land in a or r.
		if (state_q == SWait && step_q == 3'd7) cmd.dst = RegA;
		if (state_q == SWait && step_q == 3'd6) cmd.dst = RegR;
	end

	// Sequencer. Push: s*a to t, then a*o+b to o, then commit s=t.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
			req_q <= ReqPush;
			step_q <= '0;
			bit_q <= '0;
			st_q <= StOk;
			xout_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				SIdle: begin
					if (in_valid && in_ready) begin
						req_q <= req_type;
						state_q <= SDecode;
					end
				end
				SDecode: begin
					st_q <= StOk;
					xout_q <= 1'b0;
					step_q <= '0;
					state_q <= SOut;
					if (req_q == ReqPush) begin
						if (count_q == CW'(QUEUE_DEPTH)) st_q <= StFull;
						else if (sts.a_zero) st_q <= StZero;
						else state_q <= SIssue;
					end else if (req_q == ReqPop) begin
						if (count_q == '0) st_q <= StEmpty;
						else state_q <= SRead;
					end else if (req_q == ReqEval) begin
						xout_q <= 1'b1;
						state_q <= SIssue;
					end
				end
				SRead: state_q <= SRead2;
				SRead2: begin
					bit_q <= '0;
					state_q <= InvExp[0] ? SInvMul : SInvSq;
					step_q <= InvExp[0] ? 3'd6 : 3'd7;
				end
				SInvMul: state_q <= SWait;
				SInvSq: state_q <= SWait;
				SIssue: state_q <= SWait;
				SWait: begin
					if (sts.mul_done) begin
						if (step_q == 3'd6) begin
							step_q <= 3'd7;
							state_q <= SInvSq;
						end else if (step_q == 3'd7) begin
							if (bit_q == 5'd29) begin
								step_q <= 3'd0;
								state_q <= SIssue;
							end else begin
								bit_q <= bit_q + 5'd1;
								if (InvExp[bit_q + 5'd1]) begin
									step_q <= 3'd6;
									state_q <= SInvMul;
								end else begin
									state_q <= SInvSq;
								end
							end
						end else if (req_q == ReqPush && step_q == 3'd0) begin
							step_q <= 3'd1;
							state_q <= SIssue;
						end else if (req_q == ReqPop && step_q != 3'd2) begin
							step_q <= step_q + 3'd1;
							state_q <= SIssue;
						end else begin
							state_q <= SDone;
						end
					end
				end
				SDone: begin
					if (req_q == ReqPush && st_q == StOk) begin
						tail_q <= (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
						count_q <= count_q + CW'(1);
					end else if (req_q == ReqPop) begin
						head_q <= (head_q == LastIdx) ? '0 : head_q + AW'(1);
						count_q <= count_q - CW'(1);
					end
					state_q <= SOut;
				end
				SOut: begin
					out_valid <= 1'b1;
					state_q <= SIdle;
				end
				default: state_q <= SIdle;
			endcase
		end
	end
endmodule

### hdl/affine_function_queue_composite_core.sv
// ----------------------------------------------------------------------------
// affine_function_queue_composite_core
// FIFO of affine functions modulo 998244353 with a running composite.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid/in_ready/in_data) takes one beat per
// request: push (a,b), pop oldest, or evaluate the composite at x. The
// result channel (out_valid/out_ready/out_data) returns one beat per request
// with a status code and, for an evaluation, the composite value.
// Requests are handled one at a time. All products go through one shared
// pipelined modular multiplier, each awaited before the next is issued. A
// pop runs the 30 squarings and 28 multiplies of the Fermat inverse, then
// three composition products; a push uses two products and an evaluation
// one. Errors and the unused request code go from decode straight to the
// result. The next request beat is taken only once the result beat has
// been accepted. Reset empties the queue and sets the composite to the
// identity; the function memory needs no clearing. While the receiver
// stalls the result stays in the output register and no new request is
// taken.
// ----------------------------------------------------------------------------
module affine_function_queue_composite_core #(
	parameter int unsigned QUEUE_DEPTH = afq_pkg::DefQueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input afq_pkg::afq_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output afq_pkg::afq_out_t out_data
);
	import afq_pkg::*;
	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	afq_cmd_t cmd;
	afq_sts_t sts;
	logic [AW-1:0] rd_addr, wr_addr;

	// Controller.
	afq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(in_data.req_type), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
	);

	// Datapath.
	afq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .in_take(in_valid && in_ready),
		.cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr), .sts(sts), .out_item(out_data)
	);
endmodule

### hdl/afq_checker.sv
// ----------------------------------------------------------------------------
// afq_checker
// Port-level checks of the request and result channels.
// ----------------------------------------------------------------------------
`include "affine_function_queue_composite_core_defines.svh"
module afq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input afq_pkg::afq_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input afq_pkg::afq_out_t out_data
);
	import afq_pkg::*;
	// A request beat waiting for the block stays put.
	`AFQ_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data))
	// A result held back by the receiver stays put.
	`AFQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// No request is taken while a result waits.
	`AFQ_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// A request beat is never answered in the next cycle.
	`AFQ_ASSERT_NXT(a_latency, clk, arst_n, in_valid && in_ready, !out_valid)
	// Error results carry zero.
	`AFQ_ASSERT_IMP(a_zero_val, clk, arst_n, out_valid && out_data.status != StOk, out_data.result_value == '0)
endmodule

bind affine_function_queue_composite_core afq_checker u_afq_checker (.*);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the affine function queue with running composite.
// ----------------------------------------------------------------------------
// A directed table opens the run: identity evaluations after reset, operand
// reduction, pop on an empty queue, zero slopes, the unused request code and
// a short push/evaluate/pop sequence. Two random phases follow. A local
// model of the composite predicts every result beat; both channels idle and
// stall at random, with one long stretch where neither side holds back.
// ----------------------------------------------------------------------------
module tb_top;
	import afq_pkg::*;

	localparam int unsigned Depth = DefQueueDepth;
	localparam longint unsigned CycleLimit = 6000000;
	localparam logic [29:0] Max30 = 30'h3FFF_FFFF;
	localparam logic [1:0] ReqSpare = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	afq_in_t in_data;
	logic out_valid;
	logic out_ready;
	afq_out_t out_data;

	affine_function_queue_composite_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Local copy of the queue and the composite.
	logic [29:0] slope_q [Depth];
	logic [29:0] offset_q [Depth];
	int unsigned oldest;
	int unsigned next_free;
	int unsigned fill_level;
	logic [29:0] comp_slope;
	logic [29:0] comp_offset;

	afq_out_t pending_results [$];
	int unsigned mismatches;
	bit quiet;
	longint unsigned cycles;

	typedef struct packed {
		afq_in_t req;
		logic known;
		afq_out_t answer;
	} plan_row_t;

	plan_row_t plan [$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [29:0] fold(input logic [29:0] v);
		return (v >= ModP) ? v - ModP : v;
	endfunction

	function automatic logic [29:0] mod_mul(input logic [29:0] x, input logic [29:0] y);
		logic [63:0] p;
		p = {34'd0, x} * {34'd0, y};
		return 30'(p % {34'd0, ModP});
	endfunction

	function automatic logic [29:0] mod_sum(input logic [29:0] x, input logic [29:0] y);
		logic [30:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, ModP}) ? 30'(s - {1'b0, ModP}) : s[29:0];
	endfunction

	// Fermat inverse: v^(P-2) by square-and-multiply.
	function automatic logic [29:0] mod_recip(input logic [29:0] v);
		logic [29:0] acc;
		logic [29:0] sq;
		acc = 30'd1;
		sq = v;
		for (int i = 0; i < 30; i++) begin
			if (InvExp[i])
				acc = mod_mul(acc, sq);
			sq = mod_mul(sq, sq);
		end
		return acc;
	endfunction

	// Applies one request to the local queue and returns its result beat.
	function automatic afq_out_t apply_request(input afq_in_t r);
		afq_out_t res;
		logic [29:0] a;
		logic [29:0] b;
		logic [29:0] ai;
		logic [29:0] c;
		res = '0;
		res.status = StOk;
		if (r.req_type == ReqPush) begin
			a = fold(r.coef_a);
			b = fold(r.coef_b);
			if (fill_level >= Depth) begin
				res.status = StFull;
			end else if (a == 30'd0) begin
				res.status = StZero;
			end else begin
				slope_q[next_free] = a;
				offset_q[next_free] = b;
				next_free = (next_free + 1) % Depth;
				fill_level++;
				comp_slope = mod_mul(comp_slope, a);
				comp_offset = mod_sum(mod_mul(a, comp_offset), b);
			end
		end else if (r.req_type == ReqPop) begin
			if (fill_level == 0) begin
				res.status = StEmpty;
			end else begin
				a = slope_q[oldest];
				b = offset_q[oldest];
				ai = mod_recip(a);
				c = mod_mul((b == 30'd0) ? 30'd0 : ModP - b, ai);
				oldest = (oldest + 1) % Depth;
				fill_level--;
				comp_offset = mod_sum(mod_mul(comp_slope, c), comp_offset);
				comp_slope = mod_mul(comp_slope, ai);
			end
		end else if (r.req_type == ReqEval) begin
			res.result_value = mod_sum(mod_mul(comp_slope, fold(r.query_x)), comp_offset);
		end
		return res;
	endfunction

	// Offers one request beat, with an optional random gap in front of it.
	task automatic offer(input afq_in_t r, input logic known, input afq_out_t answer);
		afq_out_t predicted;
		if (!quiet && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		predicted = apply_request(r);
		if (known)
			predicted = answer;
		pending_results = {pending_results, predicted};
	endtask

	function automatic afq_in_t make_req(input logic [1:0] kind, input logic [29:0] a,
			input logic [29:0] b, input logic [29:0] x);
		afq_in_t r;
		r.req_type = kind;
		r.coef_a = a;
		r.coef_b = b;
		r.query_x = x;
		return r;
	endfunction

	function automatic void add_row(input afq_in_t r, input logic known,
			input logic [1:0] st, input logic [29:0] val);
		plan_row_t row;
		row.req = r;
		row.known = known;
		row.answer.status = st;
		row.answer.result_value = val;
		plan = {plan, row};
	endfunction

	// Random request; most are well-formed pushes, evaluations and pops.
	function automatic afq_in_t random_req();
		int unsigned pick;
		logic [29:0] a;
		pick = $urandom_range(99);
		a = 30'($urandom);
		if ($urandom_range(19) == 0)
			a = ($urandom_range(1) == 0) ? 30'd0 : ModP;
		if (pick < 45)
			return make_req(ReqPush, a, 30'($urandom), 30'($urandom));
		else if (pick < 60)
			return make_req(ReqPop, 30'($urandom), 30'($urandom), 30'($urandom));
		else if (pick < 95)
			return make_req(ReqEval, 30'($urandom), 30'($urandom), 30'($urandom));
		return make_req(ReqSpare, 30'($urandom), 30'($urandom), 30'($urandom));
	endfunction

	// Result side: random stalls and the comparison against the oldest expectation.
	always @(posedge clk) begin
		afq_out_t want;
		if (arst_n) begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: status %0d value %0d",
							out_data.status, out_data.result_value);
				end else begin
					want = pending_results.pop_front();
					if (want.status !== out_data.status ||
							want.result_value !== out_data.result_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected status %0d value %0d, got status %0d value %0d",
								want.status, want.result_value,
								out_data.status, out_data.result_value);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("affine_function_queue_composite_core regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		quiet = 1'b0;
		cycles = 0;
		mismatches = 0;
		oldest = 0;
		next_free = 0;
		fill_level = 0;
		comp_slope = 30'd1;
		comp_offset = 30'd0;

		// Directed table: identity after reset, reductions, error codes, short sequence.
		add_row(make_req(ReqEval, 30'd0, 30'd0, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, ModP - 30'd1), 1'b1, StOk, ModP - 30'd1);
		add_row(make_req(ReqEval, 30'd0, 30'd0, Max30), 1'b1, StOk, 30'd75497470);
		add_row(make_req(ReqEval, 30'd0, 30'd0, ModP), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqPop, Max30, Max30, Max30), 1'b1, StEmpty, 30'd0);
		add_row(make_req(ReqSpare, Max30, Max30, Max30), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqPush, 30'd0, 30'd7, 30'd0), 1'b1, StZero, 30'd0);
		add_row(make_req(ReqPush, ModP, Max30, 30'd0), 1'b1, StZero, 30'd0);
		add_row(make_req(ReqPush, 30'd1, 30'd0, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqPush, ModP - 30'd1, ModP - 30'd1, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqPush, Max30, Max30, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, 30'd5), 1'b0, StOk, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, Max30), 1'b0, StOk, 30'd0);
		add_row(make_req(ReqPop, 30'd0, 30'd0, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, ModP - 30'd1), 1'b0, StOk, 30'd0);
		add_row(make_req(ReqPop, 30'd0, 30'd0, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, 30'd77), 1'b0, StOk, 30'd0);
		add_row(make_req(ReqPop, 30'd0, 30'd0, 30'd0), 1'b1, StOk, 30'd0);
		add_row(make_req(ReqPop, 30'd0, 30'd0, 30'd0), 1'b1, StEmpty, 30'd0);
		add_row(make_req(ReqEval, 30'd0, 30'd0, 30'd123), 1'b1, StOk, 30'd123);

		// Hold reset, then release it.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].req, plan[i].known, plan[i].answer);

		// First random phase, with a quiet stretch in the middle.
		for (int i = 0; i < 350; i++) begin
			quiet = (i >= 150 && i < 230);
			offer(random_req(), 1'b0, '0);
		end
		quiet = 1'b0;

		// Second random phase.
		for (int i = 0; i < 330; i++)
			offer(random_req(), 1'b0, '0);
		in_valid <= 1'b0;

		// Drain, then allow for any trailing activity.
		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("affine_function_queue_composite_core regression: pass");
		else
			$display("affine_function_queue_composite_core regression: fail");
		$finish;
	end
endmodule

### sim.f
+incdir+hdl
hdl/afq_pkg.sv
hdl/afq_mulmod.sv
hdl/afq_datapath.sv
hdl/afq_ctrl.sv
hdl/affine_function_queue_composite_core.sv
hdl/afq_checker.sv
verif/tb_top.sv
